// File: hw/rtl/mfps_pkg.sv
// ============================================================================
// mfps_pkg
// Shared constants and register index codes for the falling path sum unit.
// ============================================================================
package mfps_pkg;

   // Line buffer depth and accumulated sum width.
   localparam int MAX_COLUMNS = 1024;
   localparam int SUM_WIDTH   = 32;

   localparam int COL_WIDTH   = $clog2(MAX_COLUMNS);

   // Field widths of the ports.
   localparam int CELL_WIDTH      = 16;
   localparam int PATH_SUM_WIDTH  = 32;
   localparam int GRID_COLS_WIDTH = 11;
   localparam int GRID_ROWS_WIDTH = 16;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_COLUMNS = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_ROWS    = CSR_INDEX_WIDTH'(1);

   localparam logic [GRID_COLS_WIDTH-1:0] GRID_COLUMNS_RESET = GRID_COLS_WIDTH'(100);
   localparam logic [GRID_ROWS_WIDTH-1:0] GRID_ROWS_RESET    = GRID_ROWS_WIDTH'(100);

   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

   typedef logic [SUM_WIDTH-1:0] sum_type;
   typedef logic [COL_WIDTH-1:0] col_type;

endpackage

// File: hw/rtl/max_falling_path_sum_dp_unit.sv
// ============================================================================
// max_falling_path_sum_dp_unit
// Streams grid cells in row-major order and returns, per cell, the best
// saturating falling path sum that ends there.
// ============================================================================
//
// The unit accepts one grid cell per req beat and returns exactly one rsp beat
// per cell, in order, carrying the best falling path sum ending at that cell
// and a flag on the final cell of the grid. It sustains one cell per clock
// cycle while the skid register is empty, and registers each result. The
// rate is set by the line buffer, a single memory with one read and one write
// port per cycle: every accepted cell writes its sum at its own column and
// issues a read ahead of the entry two columns on, so the upper-right value
// of the next cell is ready when it arrives. The above value of the next cell
// is that read-ahead word, and the upper-left value is the current above
// value held in a register. Column 0 of each row is also kept in a register,
// so a row change needs no second read. A two-entry output stage (output
// register plus skid register) lets the unit take a new cell while a result
// still waits on rsp. Writing any configuration register, including an index
// past the defined ones, restarts the grid at row 0, column 0; writes are
// expected only while the unit is idle. Column counts below 3 act as 3 and
// above the line buffer depth act as the depth; a row count of 0 acts as 1.
// The line buffer needs no clearing after reset, since row 0 writes every
// column in use before any later row reads it.
//
module max_falling_path_sum_dp_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   // Cell input channel.
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [mfps_pkg::CELL_WIDTH-1:0]         req_cell_value,
   // Result channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [mfps_pkg::PATH_SUM_WIDTH-1:0]     rsp_path_sum,
   output logic                                    rsp_is_last,
   // Configuration write channel.
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mfps_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mfps_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // Configuration registers.
   logic [mfps_pkg::GRID_COLS_WIDTH-1:0] grid_columns_ff;
   logic [mfps_pkg::GRID_ROWS_WIDTH-1:0] grid_rows_ff;

   // Grid position.
   mfps_pkg::col_type                    col_ff,   col_in;
   logic [mfps_pkg::GRID_ROWS_WIDTH-1:0] row_ff,   row_in;

   // Neighborhood of the current cell taken from the previous row.
   mfps_pkg::sum_type above_ff;        // previous row, this column
   mfps_pkg::sum_type held_left_ff;    // previous row, column to the left
   mfps_pkg::sum_type row_start_ff;    // this row's sum at column 0
   mfps_pkg::sum_type rd_data_ff;      // read-ahead word from the line buffer

   // Line buffer holding the previous row.
   mfps_pkg::sum_type line_mem [mfps_pkg::MAX_COLUMNS];

   // Output stage: output register plus skid register.
   logic                                 out_valid_ff;
   logic [mfps_pkg::PATH_SUM_WIDTH-1:0]  out_sum_ff;
   logic                                 out_last_ff;
   logic                                 skid_valid_ff;
   logic [mfps_pkg::PATH_SUM_WIDTH-1:0]  skid_sum_ff;
   logic                                 skid_last_ff;

   logic                                 in_accept;
   logic                                 out_accept;
   logic                                 csr_write;
   mfps_pkg::col_type                    col_last;
   logic [mfps_pkg::GRID_ROWS_WIDTH-1:0] row_last;
   logic                                 at_row_end;
   logic                                 at_grid_end;
   logic                                 is_edge;
   mfps_pkg::sum_type                    best;
   mfps_pkg::sum_type                    cell_ext;
   logic [mfps_pkg::SUM_WIDTH:0]         add_wide;
   mfps_pkg::sum_type                    sum;
   mfps_pkg::col_type                    rd_addr;
   logic [mfps_pkg::PATH_SUM_WIDTH-1:0]  sum_out;

   assign in_accept  = req_valid && req_ready;
   assign out_accept = rsp_valid && rsp_ready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;

   // The unit only stalls when both output slots are occupied.
   assign req_ready    = !skid_valid_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp_path_sum = out_sum_ff;
   assign rsp_is_last  = out_last_ff;

   // Last column and last row in use, with out-of-range settings clamped.
   always_comb begin
      if (grid_columns_ff < mfps_pkg::GRID_COLS_WIDTH'(3)) begin
         col_last = mfps_pkg::COL_WIDTH'(2);
      end else if (32'(grid_columns_ff) > 32'(mfps_pkg::MAX_COLUMNS)) begin
         col_last = mfps_pkg::COL_WIDTH'(mfps_pkg::MAX_COLUMNS - 1);
      end else begin
         col_last = mfps_pkg::COL_WIDTH'(grid_columns_ff - mfps_pkg::GRID_COLS_WIDTH'(1));
      end
      if (grid_rows_ff == '0) begin
         row_last = '0;
      end else begin
         row_last = grid_rows_ff - mfps_pkg::GRID_ROWS_WIDTH'(1);
      end
   end

   assign at_row_end  = (col_ff == col_last);
   assign at_grid_end = at_row_end && (row_ff >= row_last);
   assign is_edge     = (col_ff == '0) || at_row_end;

   // Best predecessor and the saturating sum. The upper-right value is the
   // read-ahead word that arrived from the line buffer.
   always_comb begin
      best = above_ff;
      if (!is_edge) begin
         if (held_left_ff > best) begin
            best = held_left_ff;
         end
         if (rd_data_ff > best) begin
            best = rd_data_ff;
         end
      end
      cell_ext = mfps_pkg::SUM_WIDTH'(req_cell_value);
      add_wide = {1'b0, best} + {1'b0, cell_ext};
      if (row_ff == '0) begin
         sum = cell_ext;
      end else if (add_wide[mfps_pkg::SUM_WIDTH]) begin
         sum = mfps_pkg::SUM_MAX;
      end else begin
         sum = add_wide[mfps_pkg::SUM_WIDTH-1:0];
      end
      sum_out = mfps_pkg::PATH_SUM_WIDTH'(sum);
   end

   // Next position, and the line buffer address that the next cell's
   // upper-right neighbor sits at. Past the last column the address is unused.
   always_comb begin
      if (at_row_end) begin
         col_in  = '0;
         rd_addr = mfps_pkg::COL_WIDTH'(1);
         if (at_grid_end) begin
            row_in = '0;
         end else begin
            row_in = row_ff + mfps_pkg::GRID_ROWS_WIDTH'(1);
         end
      end else begin
         col_in  = col_ff + mfps_pkg::COL_WIDTH'(1);
         rd_addr = col_ff + mfps_pkg::COL_WIDTH'(2);
         row_in  = row_ff;
      end
   end

   // Configuration registers and grid position.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= mfps_pkg::GRID_COLUMNS_RESET;
         grid_rows_ff    <= mfps_pkg::GRID_ROWS_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else if (csr_write) begin
         if (csr_index == mfps_pkg::REG_GRID_COLUMNS) begin
            grid_columns_ff <= csr_wdata[mfps_pkg::GRID_COLS_WIDTH-1:0];
         end else if (csr_index == mfps_pkg::REG_GRID_ROWS) begin
            grid_rows_ff <= csr_wdata[mfps_pkg::GRID_ROWS_WIDTH-1:0];
         end
         col_ff <= '0;
         row_ff <= '0;
      end else if (in_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Neighborhood registers. Their contents only matter once row 0 has
   // filled the line buffer, so they need no reset.
   always_ff @(posedge clock) begin
      if (in_accept) begin
         held_left_ff <= above_ff;
         if (col_ff == '0) begin
            row_start_ff <= sum;
         end
         if (at_row_end) begin
            // Column 0 of the next row sits below this row's first sum; it
            // is taken from the register, or from this sum in a row of one.
            above_ff <= (col_ff == '0) ? sum : row_start_ff;
         end else begin
            above_ff <= rd_data_ff;
         end
      end
   end

   // Line buffer: write this cell's sum, read ahead for the next cell. The
   // two addresses always differ since a row has at least three columns.
   always_ff @(posedge clock) begin
      if (in_accept) begin
         line_mem[col_ff] <= sum;
         rd_data_ff       <= line_mem[rd_addr];
      end
   end

   // Output register and skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (in_accept) begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (out_accept) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         if (!out_valid_ff || rsp_ready) begin
            out_sum_ff  <= sum_out;
            out_last_ff <= at_grid_end;
         end else begin
            skid_sum_ff  <= sum_out;
            skid_last_ff <= at_grid_end;
         end
      end else if (out_accept && skid_valid_ff) begin
         out_sum_ff  <= skid_sum_ff;
         out_last_ff <= skid_last_ff;
      end
   end

endmodule
